@@ rtl/core/crt_pkg.sv @@
package crt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int KIND_BITS = 8;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CFG_W = 32;
	localparam int QDEPTH = 2;

	localparam logic [7:0] KIND_ALL = 8'((64'd1 << KIND_BITS) - 64'd1);

	typedef enum logic [2:0] {
		CMD_PREPARE  = 3'd0,
		CMD_BEGIN    = 3'd1,
		CMD_FINISH   = 3'd2,
		CMD_QUERY    = 3'd3,
		CMD_NEXT     = 3'd4,
		CMD_SHUTDOWN = 3'd5,
		CMD_TICK     = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_KINDS   = 1'b1;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] client_id;
		logic [7:0]  kind_mask;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        recovery_done;
		logic        owes_kinds;
		logic [63:0] next_client;
		logic        timed_out;
	} rsp_t;

	// classified item handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] id;
		logic [7:0]  mask;
		logic        bad_kinds;
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_APPLY
	} bk_state_t;

endpackage

@@ rtl/core/client_recovery_tracker.sv @@
// Client recovery tracker.
// Command port: an item (command, client_id, kind_mask) is taken on a clock
// edge with start high and busy low. Each item gives exactly one result on
// result, marked by done for one cycle; the receiver cannot stall it.
// A two-entry queue parts the front (accept, kind check) from the back,
// which scans the 16-entry table one entry a cycle and then applies.
// The front keeps taking items while the back scans, until the two-entry
// queue is full; busy rises while the queue is full.
// Config: cfg_we with cfg_index 0 writes timeout_ticks, 1 writes
// valid_kinds (low 8 bits). Write only while idle.
// Reset (arst_n low) empties the table, clears begun/armed state, the
// countdown and the queue, and restores timeout_ticks 1000, valid_kinds 255.
module client_recovery_tracker import crt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [31:0] timeout_ticks_q;
	logic [7:0]  valid_kinds_q;
	logic        q_valid, pop;
	op_t         q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= 32'd1000;
			valid_kinds_q <= 8'd255;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TIMEOUT) timeout_ticks_q <= cfg_data;
			else valid_kinds_q <= cfg_data[7:0];
		end
	end

	crt_front u_front (
		.clk, .arst_n, .start, .req, .valid_kinds_q, .pop, .busy, .q_valid, .q_head
	);

	crt_back u_back (
		.clk, .arst_n, .q_valid, .q_head, .timeout_ticks_q, .pop, .done, .rsp(result)
	);

endmodule

@@ rtl/core/crt_front.sv @@
module crt_front import crt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       req,
	input  logic [7:0] valid_kinds_q,
	input  logic       pop,
	output logic       busy,
	output logic       q_valid,
	output op_t        q_head
);

	op_t  slot_q [QDEPTH];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;
	op_t  op;

	assign busy = (cnt_q == 2'(QDEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = slot_q[rd_q];

	// flag kinds outside the accepted mask up front
	always_comb begin
		op.cmd = cmd_t'(req.command);
		op.id = req.client_id;
		op.mask = req.kind_mask;
		op.bad_kinds = (req.kind_mask & ~(valid_kinds_q & KIND_ALL)) != 8'd0;
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/core/crt_back.sv @@
module crt_back import crt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  op_t         q_head,
	input  logic [31:0] timeout_ticks_q,
	output logic        pop,
	output logic        done,
	output rsp_t        rsp
);

	bk_state_t state_q, state_d;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [63:0] client_q [TABLE_ENTRIES];
	logic [7:0]  kinds_q  [TABLE_ENTRIES];
	logic        begun_q, armed_q;
	logic [31:0] ticks_q;

	op_t          op_q;
	logic [CNT_W-1:0] idx_q;
	logic         hit_q, free_found_q, next_found_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [63:0]  next_q;
	logic [IDX_W-1:0] cur;
	logic         last;
	logic         match_any, match_mask, nxt_ok;

	assign cur = idx_q[IDX_W-1:0];
	assign last = (idx_q == CNT_W'(TABLE_ENTRIES - 1));
	assign match_any = valid_q[cur] && client_q[cur] == op_q.id;
	assign match_mask = match_any && (kinds_q[cur] & op_q.mask) != 8'd0;
	assign nxt_ok = valid_q[cur] && client_q[cur] > op_q.id
		&& (kinds_q[cur] & op_q.mask) != 8'd0
		&& (!next_found_q || client_q[cur] < next_q);
	assign pop = (state_q == BK_IDLE) && q_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (q_valid) state_d = BK_SCAN;
			BK_SCAN:  if (last) state_d = BK_APPLY;
			BK_APPLY: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// scan: one entry a cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_head;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			next_found_q <= 1'b0;
			next_q <= '0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else if (state_q == BK_SCAN) begin
			if (!last) idx_q <= idx_q + 1'b1;
			if (!hit_q && ((op_q.cmd == CMD_PREPARE) ? match_any : match_mask)) begin
				hit_q <= 1'b1;
				hit_idx_q <= cur;
			end
			if (!free_found_q && !valid_q[cur]) begin
				free_found_q <= 1'b1;
				free_idx_q <= cur;
			end
			if (nxt_ok) begin
				next_found_q <= 1'b1;
				next_q <= client_q[cur];
			end
		end
	end

	logic [7:0] cleared;
	logic       others;
	assign cleared = kinds_q[hit_idx_q] & ~op_q.mask & KIND_ALL;
	// set when an entry other than the hit one is still valid
	always_comb begin
		logic [TABLE_ENTRIES-1:0] v;
		v = valid_q;
		v[hit_idx_q] = 1'b0;
		others = (v != '0);
	end

	rsp_t rsp_d;
	always_comb begin
		rsp_d = '0;
		case (op_q.cmd)
			CMD_PREPARE: begin
				if (op_q.bad_kinds) rsp_d.status = ST_INVALID;
				else if (!hit_q && !free_found_q) rsp_d.status = ST_FULL;
			end
			CMD_BEGIN:  rsp_d.recovery_done = (valid_q == '0);
			CMD_FINISH: rsp_d.recovery_done = hit_q && cleared == 8'd0 && begun_q && !others;
			CMD_QUERY:  rsp_d.owes_kinds = hit_q;
			CMD_NEXT:   rsp_d.next_client = next_q;
			CMD_TICK:   rsp_d.timed_out = armed_q && ticks_q <= 32'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_APPLY) begin
			if (op_q.cmd == CMD_PREPARE && !op_q.bad_kinds) begin
				if (hit_q) kinds_q[hit_idx_q] <= kinds_q[hit_idx_q] | op_q.mask;
				else if (free_found_q) begin
					client_q[free_idx_q] <= op_q.id;
					kinds_q[free_idx_q] <= op_q.mask;
				end
			end
			if (op_q.cmd == CMD_FINISH && hit_q) kinds_q[hit_idx_q] <= cleared;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			begun_q <= 1'b0;
			armed_q <= 1'b0;
			ticks_q <= '0;
			done <= 1'b0;
			rsp <= '0;
		end else begin
			done <= (state_q == BK_APPLY);
			if (state_q == BK_APPLY) begin
				rsp <= rsp_d;
				case (op_q.cmd)
					CMD_PREPARE: begin
						if (!op_q.bad_kinds && !hit_q && free_found_q)
							valid_q[free_idx_q] <= 1'b1;
					end
					CMD_BEGIN: begin
						begun_q <= 1'b1;
						ticks_q <= timeout_ticks_q;
						armed_q <= (valid_q != '0);
					end
					CMD_FINISH: begin
						if (hit_q && cleared == 8'd0) begin
							valid_q[hit_idx_q] <= 1'b0;
							if (begun_q && !others) armed_q <= 1'b0;
						end
					end
					CMD_SHUTDOWN: begin
						valid_q <= '0;
						begun_q <= 1'b0;
						armed_q <= 1'b0;
						ticks_q <= '0;
					end
					CMD_TICK: begin
						if (armed_q) begin
							if (ticks_q <= 32'd1) begin
								ticks_q <= '0;
								armed_q <= 1'b0;
							end else ticks_q <= ticks_q - 32'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

@@ sim/testbench.sv @@
module testbench;
	import crt_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             result;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	client_recovery_tracker u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// tracker model state
	logic [31:0] m_timeout;
	logic [7:0]  m_kinds_ok;
	logic        m_valid [TABLE_ENTRIES];
	logic [63:0] m_client [TABLE_ENTRIES];
	logic [7:0]  m_kinds [TABLE_ENTRIES];
	logic        m_begun;
	logic        m_armed;
	logic [31:0] m_ticks;

	req_t pending_items[$];
	rsp_t expected_rsp[$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   rsp_seen = 0;
	int   timeouts_seen = 0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   rx_phase = 0;
	logic [63:0] id_pool [12];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic table_is_empty();
		foreach (m_valid[i])
			if (m_valid[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic rsp_t track_recovery(req_t r);
		rsp_t o;
		int   slot;
		logic found;
		o = '0;
		slot = -1;
		found = 1'b0;
		case (cmd_t'(r.command))
			CMD_PREPARE: begin
				if ((r.kind_mask & ~(m_kinds_ok & KIND_ALL)) != 0) begin
					o.status = ST_INVALID;
				end else begin
					foreach (m_valid[i])
						if (slot < 0 && m_valid[i] && m_client[i] == r.client_id)
							slot = i;
					if (slot >= 0) begin
						m_kinds[slot] |= r.kind_mask;
					end else begin
						foreach (m_valid[i])
							if (slot < 0 && !m_valid[i])
								slot = i;
						if (slot < 0) begin
							o.status = ST_FULL;
						end else begin
							m_valid[slot] = 1'b1;
							m_client[slot] = r.client_id;
							m_kinds[slot] = r.kind_mask;
						end
					end
				end
			end
			CMD_BEGIN: begin
				m_begun = 1'b1;
				m_armed = 1'b1;
				m_ticks = m_timeout;
				if (table_is_empty()) begin
					o.recovery_done = 1'b1;
					m_armed = 1'b0;
				end
			end
			CMD_FINISH: begin
				foreach (m_valid[i])
					if (slot < 0 && m_valid[i] && m_client[i] == r.client_id &&
					    (m_kinds[i] & r.kind_mask) != 0)
						slot = i;
				if (slot >= 0) begin
					m_kinds[slot] &= ~r.kind_mask & KIND_ALL;
					if (m_kinds[slot] == 0) begin
						m_valid[slot] = 1'b0;
						if (m_begun && table_is_empty()) begin
							o.recovery_done = 1'b1;
							m_armed = 1'b0;
						end
					end
				end
			end
			CMD_QUERY: begin
				foreach (m_valid[i])
					if (m_valid[i] && m_client[i] == r.client_id &&
					    (m_kinds[i] & r.kind_mask) != 0)
						o.owes_kinds = 1'b1;
			end
			CMD_NEXT: begin
				foreach (m_valid[i])
					if (m_valid[i] && m_client[i] > r.client_id &&
					    (m_kinds[i] & r.kind_mask) != 0 &&
					    (!found || m_client[i] < o.next_client)) begin
						o.next_client = m_client[i];
						found = 1'b1;
					end
			end
			CMD_SHUTDOWN: begin
				foreach (m_valid[i])
					m_valid[i] = 1'b0;
				m_begun = 1'b0;
				m_armed = 1'b0;
				m_ticks = '0;
			end
			CMD_TICK: begin
				if (m_armed) begin
					if (m_ticks <= 1) begin
						m_ticks = '0;
						m_armed = 1'b0;
						o.timed_out = 1'b1;
					end else begin
						m_ticks--;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// driver: bursts of items with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_rsp.push_back(track_recovery(req));
				void'(pending_items.pop_front());
				items_sent++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (pending_items.size() > 0) begin
					start <= 1'b1;
					req <= pending_items[0];
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		rx_phase <= rx_phase + 1;
		if (arst_n && done) begin
			rsp_seen++;
			if (result.timed_out)
				timeouts_seen++;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = expected_rsp.pop_front();
				if (result.status !== want.status ||
				    result.recovery_done !== want.recovery_done ||
				    result.owes_kinds !== want.owes_kinds ||
				    result.next_client !== want.next_client ||
				    result.timed_out !== want.timed_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected st=%0d dn=%0b pd=%0b nx=%h to=%0b,",
							" got st=%0d dn=%0b pd=%0b nx=%h to=%0b"},
							want.status, want.recovery_done, want.owes_kinds,
							want.next_client, want.timed_out, result.status,
							result.recovery_done, result.owes_kinds,
							result.next_client, result.timed_out);
				end
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TIMEOUT)
			m_timeout = value;
		else
			m_kinds_ok = value[7:0];
	endtask

	task automatic wait_quiet();
		wait (pending_items.size() == 0 && !start && expected_rsp.size() == 0);
		repeat (25) @(posedge clk);
	endtask

	task automatic add_item(input cmd_t c, input logic [63:0] id, input logic [7:0] mask);
		req_t r;
		r.command = c;
		r.client_id = id;
		r.kind_mask = mask;
		pending_items.push_back(r);
	endtask

	task automatic add_random(input int count);
		req_t r;
		int   pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) r.command = CMD_PREPARE;
			else if (pick < 55) r.command = CMD_FINISH;
			else if (pick < 65) r.command = CMD_QUERY;
			else if (pick < 75) r.command = CMD_NEXT;
			else if (pick < 83) r.command = CMD_BEGIN;
			else if (pick < 95) r.command = CMD_TICK;
			else if (pick < 97) r.command = CMD_SHUTDOWN;
			else r.command = CMD_NONE;
			if ($urandom_range(0, 9) == 0)
				r.client_id = {$urandom, $urandom};
			else
				r.client_id = id_pool[$urandom_range(0, 11)];
			r.kind_mask = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
				8'(1 << $urandom_range(0, 7));
			pending_items.push_back(r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		m_timeout = 32'd1000;
		m_kinds_ok = 8'hFF;
		foreach (m_valid[i]) begin
			m_valid[i] = 1'b0;
			m_client[i] = '0;
			m_kinds[i] = '0;
		end
		m_begun = 1'b0;
		m_armed = 1'b0;
		m_ticks = '0;
		foreach (id_pool[i])
			id_pool[i] = 64'(i);
		id_pool[9] = 64'hFFFF_FFFF_FFFF_FFFF;
		id_pool[10] = 64'h8000_0000_0000_0000;
		id_pool[11] = 64'h5A5A_A5A5_0F0F_F0F0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, id extremes, full table, unused command
		add_item(CMD_BEGIN, 64'd0, 8'd0);
		add_item(CMD_PREPARE, 64'd0, 8'h00);
		add_item(CMD_PREPARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80);
		add_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		add_item(CMD_NEXT, 64'd0, 8'hFF);
		add_item(CMD_NEXT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		add_item(CMD_FINISH, 64'd5, 8'h01);
		for (int i = 1; i <= 14; i++)
			add_item(CMD_PREPARE, 64'(i), 8'(i));
		add_item(CMD_PREPARE, 64'd100, 8'h01);
		add_item(CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		add_item(CMD_SHUTDOWN, 64'd0, 8'd0);
		add_item(CMD_TICK, 64'd0, 8'd0);
		wait_quiet();

		write_reg(CFG_TIMEOUT, 32'd0);
		add_random(90);
		wait_quiet();
		write_reg(CFG_TIMEOUT, 32'd3);
		write_reg(CFG_KINDS, 32'h0F);
		add_random(90);
		wait_quiet();
		write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(CFG_KINDS, 32'h00);
		add_random(70);
		wait_quiet();
		write_reg(CFG_TIMEOUT, 32'd1);
		write_reg(CFG_KINDS, 32'hA5);
		add_random(90);
		wait_quiet();
		write_reg(CFG_TIMEOUT, 32'd6);
		write_reg(CFG_KINDS, 32'hFF);
		add_random(90);
		wait_quiet();

		$display("covered %0d items over six register settings, %0d results, %0d timeouts",
			items_sent, rsp_seen, timeouts_seen);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_rsp.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/crt_pkg.sv
rtl/core/crt_front.sv
rtl/core/crt_back.sv
rtl/core/client_recovery_tracker.sv
sim/testbench.sv
